### rtl/ctq_pkg.sv
// Shared types and constants for the congruence transform block.
`default_nettype none
package ctq_pkg;
	localparam int unsigned ValW = 32;
	localparam int unsigned ProdW = 64;
	localparam int unsigned AccW = 72;
	typedef enum logic [1:0] {
		FUNC_LOAD_K = 2'd0,
		FUNC_LOAD_Q = 2'd1,
		FUNC_START = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TEMP = 4'b0010,
		ST_DOT = 4'b0100,
		ST_OUT = 4'b1000
	} state_t;
	// Cell control, broadcast along the chain.
	typedef struct packed {
		logic clear;
		logic acc_en;
	} cell_ctl_t;

	// Shift right by 16 (floor) and saturate to signed 32 bits.
	function automatic logic [ValW:0] sat_q16(input logic signed [AccW-1:0] a);
		logic signed [AccW-17:0] sh;
		logic [ValW:0] r;
		begin
			sh = a[AccW-1:16];
			if (sh > $signed({{(AccW-48){1'b0}}, 32'h7FFF_FFFF}))
				r = {1'b1, 32'h7FFF_FFFF};
			else if (sh < $signed({{(AccW-48){1'b1}}, 32'h8000_0000}))
				r = {1'b1, 32'h8000_0000};
			else
				r = {1'b0, sh[ValW-1:0]};
			return r;
		end
	endfunction
endpackage
`default_nettype wire

### rtl/ctq_cell.sv
// One multiply-accumulate cell of the chain; passes its operand to the neighbor.
`default_nettype none
module ctq_cell (
	input  wire logic                          clk,
	input  wire ctq_pkg::cell_ctl_t            ctl,
	input  wire logic signed [31:0]            a_in,
	input  wire logic signed [31:0]            b,
	output logic signed [31:0]                 a_out,
	output logic signed [ctq_pkg::AccW-1:0]    acc
);
	logic signed [ctq_pkg::ProdW-1:0] prod_q;
	logic                             en_q;
	logic                             clr_q;

	// Hand the operand on to the neighbor.
	assign a_out = a_in;

	// Register the product, then accumulate.
	always_ff @(posedge clk) begin
		prod_q <= a_in * b;
		en_q   <= ctl.acc_en;
		clr_q  <= ctl.clear;
		if (clr_q)
			acc <= '0;
		else if (en_q)
			acc <= acc + {{(ctq_pkg::AccW-ctq_pkg::ProdW){prod_q[ctq_pkg::ProdW-1]}}, prod_q};
	end
endmodule
`default_nettype wire

### rtl/congruence_transform_qtkq_top.sv
// Top level of the Q^T K Q congruence transform.
// Usage: send words on s_axis (tdata = value/col/row packed, tuser = func).
// Function 0 loads K[row][col], 1 loads Q[row][col].
// Function 2 starts the product; n*n results leave on m_axis in row-major
// order, tlast on the final one. A row of MAX_DIM cells each owns one output
// column i, and the common operand passes from cell to cell: in the temporary
// phase cell i accumulates K[k][i]*Q[k][j] over k; in the dot phase it
// accumulates t[k]*Q[k][i]. One k per cycle, reading one memory row per
// cycle; each row j computes both phases and then streams its results,
// which wait while the receiver stalls. s_axis_tready is low while a start
// is busy. The result register holds its word while m_axis_tready is low
// and the sequencer waits. Reset clears control and sets dim_q to 8; the
// stores are undefined until loaded.
`default_nettype none
module congruence_transform_qtkq_top #(
	parameter int unsigned MAX_DIM = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // row[2:0], col[5:3], value[37:6]
	input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6]
	output logic             m_axis_tlast,  // last
	output logic             m_axis_tuser   // overflow
);
	localparam int unsigned IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned CW = $clog2(MAX_DIM + 1);
	localparam int unsigned DRAIN = 3;

	logic [3:0] dim_q;
	logic [CW-1:0] n;
	ctq_pkg::state_t st_q;
	logic [IW-1:0] j_q, k_q, o_q;
	logic [CW:0] cnt_q;
	logic [MAX_DIM-1:0][31:0] k_mem [MAX_DIM];
	logic [MAX_DIM-1:0][31:0] q_mem [MAX_DIM];
	logic [MAX_DIM-1:0][31:0] krow_q, qrow_q;
	logic [MAX_DIM-1:0][31:0] temp_q;
	logic [MAX_DIM-1:0] tsat_q;
	logic [MAX_DIM-1:0] osat_q;
	logic [MAX_DIM-1:0][31:0] ores_q;
	logic signed [31:0] a_chain [MAX_DIM+1];
	logic signed [ctq_pkg::AccW-1:0] acc [MAX_DIM];
	logic [MAX_DIM-1:0] live;
	ctq_pkg::cell_ctl_t ctl;
	logic rd_s1, clr_req, any_tsat;
	logic [2:0] f_row, f_col;
	logic [31:0] f_val;
	ctq_pkg::func_t f_func;
	logic s_hs;

	assign f_row  = s_axis_tdata[2:0];
	assign f_col  = s_axis_tdata[5:3];
	assign f_val  = s_axis_tdata[37:6];
	assign f_func = ctq_pkg::func_t'(s_axis_tuser);
	assign s_axis_tready = (st_q == ctq_pkg::ST_IDLE);
	assign s_hs = s_axis_tvalid && s_axis_tready;

	// Clamp the configured dimension.
	always_comb begin
		if (dim_q == 4'd0)
			n = CW'(1);
		else if (32'(dim_q) > MAX_DIM)
			n = CW'(MAX_DIM);
		else
			n = CW'(dim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dim_q <= 4'd8;
		else if (cfg_we)
			dim_q <= cfg_wdata;
	end

	// Store loads, and one registered row read per cycle.
	always_ff @(posedge clk) begin
		if (s_hs && f_func == ctq_pkg::FUNC_LOAD_K && 32'(f_row) < MAX_DIM
			&& 32'(f_col) < MAX_DIM)
			k_mem[f_row[IW-1:0]][f_col[IW-1:0]] <= f_val;
		if (s_hs && f_func == ctq_pkg::FUNC_LOAD_Q && 32'(f_row) < MAX_DIM
			&& 32'(f_col) < MAX_DIM)
			q_mem[f_row[IW-1:0]][f_col[IW-1:0]] <= f_val;
		krow_q <= k_mem[k_q];
		qrow_q <= q_mem[k_q];
	end

	// Operand per cell: temp phase uses column j of Q broadcast, dot uses t[k].
	logic st_temp_s1;
	logic [IW-1:0] k_q_s1;
	always_ff @(posedge clk) st_temp_s1 <= (st_q == ctq_pkg::ST_TEMP);
	always_ff @(posedge clk) k_q_s1 <= k_q;
	assign a_chain[0] = st_temp_s1 ? $signed(qrow_q[j_q]) : $signed(temp_q[k_q_s1]);

	assign ctl.clear  = clr_req;
	assign ctl.acc_en = rd_s1;

	genvar g;
	generate
		for (g = 0; g < MAX_DIM; g++) begin : g_cell
			logic signed [31:0] a_loc;
			logic signed [31:0] b_loc;
			assign b_loc = st_temp_s1 ? $signed(krow_q[g]) : $signed(qrow_q[g]);
			ctq_cell u_cell (
				.clk  (clk),
				.ctl  (ctl),
				.a_in (a_chain[g]),
				.b    (b_loc),
				.a_out(a_loc),
				.acc  (acc[g])
			);
			assign a_chain[g+1] = a_loc;
			assign live[g] = (g < n);
		end
	endgenerate

	always_comb begin
		any_tsat = 1'b0;
		for (int i = 0; i < MAX_DIM; i++)
			if (live[i] && tsat_q[i])
				any_tsat = 1'b1;
	end

	logic m_free;
	assign m_free = !m_axis_tvalid || m_axis_tready;

	// Sequencer: temp pass, dot pass, output stream per row j.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ctq_pkg::ST_IDLE;
			j_q <= '0; k_q <= '0; o_q <= '0; cnt_q <= '0;
			rd_s1 <= 1'b0; clr_req <= 1'b0;
			tsat_q <= '0; temp_q <= '0;
			osat_q <= '0; ores_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tlast <= 1'b0;
			m_axis_tuser <= 1'b0;
		end else begin
			rd_s1 <= 1'b0;
			clr_req <= 1'b0;
			if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			unique case (st_q) inside
				ctq_pkg::ST_IDLE: begin
					if (s_hs && f_func == ctq_pkg::FUNC_START) begin
						st_q <= ctq_pkg::ST_TEMP;
						j_q <= '0; k_q <= '0; cnt_q <= '0;
						clr_req <= 1'b1;
					end
				end
				ctq_pkg::ST_TEMP, ctq_pkg::ST_DOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q >= (CW+1)'(1) && cnt_q <= (CW+1)'(n)) begin
						rd_s1 <= 1'b1;
						k_q <= (cnt_q == (CW+1)'(n)) ? '0 : k_q + 1'b1;
					end
					if (cnt_q == (CW+1)'(n) + (CW+1)'(DRAIN) + (CW+1)'(2)) begin
						cnt_q <= '0;
						clr_req <= 1'b1;
						if (st_q == ctq_pkg::ST_TEMP) begin
							for (int i = 0; i < MAX_DIM; i++) begin
								{tsat_q[i], temp_q[i]} <= ctq_pkg::sat_q16(acc[i]);
							end
							st_q <= ctq_pkg::ST_DOT;
						end else begin
							for (int i = 0; i < MAX_DIM; i++) begin
								{osat_q[i], ores_q[i]} <= ctq_pkg::sat_q16(acc[i]);
							end
							o_q <= '0;
							st_q <= ctq_pkg::ST_OUT;
						end
					end
				end
				ctq_pkg::ST_OUT: begin
					if (m_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata <= {2'b00, ores_q[o_q], 3'(o_q), 3'(j_q)};
						m_axis_tuser <= osat_q[o_q] || any_tsat;
						m_axis_tlast <= (CW'(j_q) == n - 1'b1) && (CW'(o_q) == n - 1'b1);
						if (CW'(o_q) == n - 1'b1) begin
							if (CW'(j_q) == n - 1'b1) begin
								st_q <= ctq_pkg::ST_IDLE;
							end else begin
								j_q <= j_q + 1'b1;
								k_q <= '0;
								cnt_q <= '0;
								st_q <= ctq_pkg::ST_TEMP;
							end
						end else begin
							o_q <= o_q + 1'b1;
						end
					end
				end
				default: st_q <= ctq_pkg::ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
